// ===== src/gmtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and sizing constants of the grid map text parser.
package gmtp_pkg;

  localparam int MAX_COLS      = 4096;
  localparam int MAX_ROWS      = 4096;
  localparam int PLAYER_DIGITS = 3;

  localparam int CH_W    = 8;
  localparam int KIND_W  = 3;
  localparam int PID_W   = 10;
  localparam int DIR_W   = 3;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 13;
  localparam int OROW_W  = 12;
  localparam int WID_W   = 12;
  localparam int HGT_W   = 13;
  localparam int DCNT_W  = $clog2(PLAYER_DIGITS + 1);
  localparam int PID_MAX = (1 << PID_W) - 1;
  localparam int OROW_MAX = (1 << OROW_W) - 1;

  localparam int RES_BITS  = KIND_W + CH_W + PID_W + DIR_W + COL_W + OROW_W + WID_W + HGT_W;
  localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;
  localparam int TDATA_PAD = TDATA_W - RES_BITS;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBR   = 8'h5D;
  localparam logic [CH_W-1:0] CH_U     = 8'h55;
  localparam logic [CH_W-1:0] CH_D     = 8'h44;
  localparam logic [CH_W-1:0] CH_L     = 8'h4C;
  localparam logic [CH_W-1:0] CH_R     = 8'h52;

  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [3:0] {
    CLS_OTHER = 4'd0,
    CLS_END   = 4'd1,
    CLS_NL    = 4'd2,
    CLS_BLANK = 4'd3,
    CLS_DOT   = 4'd4,
    CLS_SLASH = 4'd5,
    CLS_LBR   = 4'd6,
    CLS_RBR   = 4'd7,
    CLS_DIGIT = 4'd8,
    CLS_DIRL  = 4'd9
  } cls_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OBJECT  = 3'd0,
    KIND_END     = 3'd1,
    KIND_ROWLEN  = 3'd2,
    KIND_BRACKET = 3'd3,
    KIND_BADDIR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_PLAYER = 3'b010,
    MODE_ORIENT = 3'b100
  } mode_t;

  typedef struct packed {
    cls_t              cls;
    logic [CH_W-1:0]   ch;
    logic [DIR_W-1:0]  dir;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [CH_W-1:0]    map_char;
    logic [PID_W-1:0]   player_id;
    logic [DIR_W-1:0]   direction;
    logic [COL_W-1:0]   col;
    logic [OROW_W-1:0]  row;
    logic [WID_W-1:0]   map_width;
    logic [HGT_W-1:0]   map_height;
    logic               last;
  } result_t;

  // Handshake between the classify stage and the item queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

// ===== src/gmtp_front.sv =====
`timescale 1ns / 1ps
// Front stage: accept input items, classify the character, hand to the queue.
module gmtp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [gmtp_pkg::CH_W-1:0]  ch,
  output gmtp_pkg::push_t            push,
  input  logic                       push_ready
);

  logic            fv;
  gmtp_pkg::item_t fitem;
  gmtp_pkg::item_t citem;

  function automatic gmtp_pkg::item_t classify(input logic o, input logic [7:0] c);
    gmtp_pkg::item_t r;
    r.ch  = c;
    r.dir = gmtp_pkg::DIR_NONE;
    r.cls = gmtp_pkg::CLS_OTHER;
    if (o == gmtp_pkg::OP_END) begin
      r.cls = gmtp_pkg::CLS_END;
    end else if (c == gmtp_pkg::CH_NL) begin
      r.cls = gmtp_pkg::CLS_NL;
    end else if (c inside {gmtp_pkg::CH_SPACE, gmtp_pkg::CH_TAB}) begin
      r.cls = gmtp_pkg::CLS_BLANK;
    end else if (c == gmtp_pkg::CH_DOT) begin
      r.cls = gmtp_pkg::CLS_DOT;
    end else if (c == gmtp_pkg::CH_SLASH) begin
      r.cls = gmtp_pkg::CLS_SLASH;
    end else if (c == gmtp_pkg::CH_LBR) begin
      r.cls = gmtp_pkg::CLS_LBR;
    end else if (c == gmtp_pkg::CH_RBR) begin
      r.cls = gmtp_pkg::CLS_RBR;
    end else if (c inside {[gmtp_pkg::CH_0:gmtp_pkg::CH_9]}) begin
      r.cls = gmtp_pkg::CLS_DIGIT;
    end else if (c == gmtp_pkg::CH_U) begin
      r.cls = gmtp_pkg::CLS_DIRL;
      r.dir = gmtp_pkg::DIR_UP;
    end else if (c == gmtp_pkg::CH_D) begin
      r.cls = gmtp_pkg::CLS_DIRL;
      r.dir = gmtp_pkg::DIR_DOWN;
    end else if (c == gmtp_pkg::CH_L) begin
      r.cls = gmtp_pkg::CLS_DIRL;
      r.dir = gmtp_pkg::DIR_LEFT;
    end else if (c == gmtp_pkg::CH_R) begin
      r.cls = gmtp_pkg::CLS_DIRL;
      r.dir = gmtp_pkg::DIR_RIGHT;
    end
    return r;
  endfunction

  assign citem      = classify(op, ch);
  assign in_ready   = !fv || push_ready;
  assign push.valid = fv;
  assign push.item  = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fitem <= citem;
    end
  end

endmodule

// ===== src/gmtp_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified items between the front and back stages.
module gmtp_queue (
  input  logic              clk,
  input  logic              rst,
  input  gmtp_pkg::push_t   push,
  output logic              push_ready,
  output logic              head_valid,
  output gmtp_pkg::item_t   head,
  input  logic              pop
);

  gmtp_pkg::item_t                 ent [gmtp_pkg::IQ_DEPTH];
  logic [gmtp_pkg::IQ_AW-1:0]      wptr;
  logic [gmtp_pkg::IQ_AW-1:0]      rptr;
  logic [gmtp_pkg::IQ_CW-1:0]      cnt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = cnt != gmtp_pkg::IQ_CW'(gmtp_pkg::IQ_DEPTH);
  assign head_valid = cnt != '0;
  assign head       = ent[rptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wptr] <= push.item;
    end
  end

endmodule

// ===== src/gmtp_back.sv =====
`timescale 1ns / 1ps
// Back stage: parser state, result building and the result queue.
module gmtp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  gmtp_pkg::item_t    head,
  output logic               pop,
  output logic               res_valid,
  output gmtp_pkg::result_t  res,
  input  logic               res_ready
);

  gmtp_pkg::mode_t                   mode, mode_next;
  logic [gmtp_pkg::CH_W-1:0]         pchar, pchar_next;
  logic [gmtp_pkg::PID_W-1:0]        pplayer, pplayer_next;
  logic [gmtp_pkg::DCNT_W-1:0]       dcnt, dcnt_next;
  logic [gmtp_pkg::DIR_W-1:0]        pdir, pdir_next;
  logic [gmtp_pkg::COL_W-1:0]        col_count, col_next;
  logic [gmtp_pkg::ROW_W-1:0]        row_count, row_next;
  logic [gmtp_pkg::COL_W-1:0]        first_cols, first_next;
  logic                              prev_nl, prev_nl_next;

  gmtp_pkg::result_t                 r [2];
  logic [1:0]                        nres;
  logic                              do_reset;
  logic [gmtp_pkg::COL_W-1:0]        col_a, col_b, c_nl;
  logic [gmtp_pkg::HGT_W-1:0]        hgt;
  logic [gmtp_pkg::OROW_W-1:0]       row_out;
  logic [13:0]                       pid_acc;
  logic                              pending;

  gmtp_pkg::result_t                 oq [gmtp_pkg::OQ_DEPTH];
  logic [gmtp_pkg::OQ_AW-1:0]        owptr, orptr;
  logic [gmtp_pkg::OQ_CW-1:0]        occ;
  logic                              out_take;

  function automatic logic [gmtp_pkg::COL_W-1:0] col_inc(input logic [gmtp_pkg::COL_W-1:0] c);
    return (c < gmtp_pkg::COL_W'(gmtp_pkg::MAX_COLS - 1)) ? c + 1'b1 : c;
  endfunction

  // Take an item only when two result slots are free
  assign pop      = head_valid && (occ <= gmtp_pkg::OQ_CW'(gmtp_pkg::OQ_DEPTH - 2));
  assign res_valid = occ != '0;
  assign res       = oq[orptr];
  assign out_take  = res_valid && res_ready;

  assign col_a   = col_inc(col_count);
  assign col_b   = col_inc(col_a);
  assign pending = mode != gmtp_pkg::MODE_NORMAL;
  assign row_out = (row_count > gmtp_pkg::ROW_W'(gmtp_pkg::OROW_MAX)) ?
                   gmtp_pkg::OROW_W'(gmtp_pkg::OROW_MAX) : row_count[gmtp_pkg::OROW_W-1:0];
  assign pid_acc = {pplayer, 3'b000} + {3'b000, pplayer, 1'b0} + {10'd0, head.ch[3:0]};

  always_comb begin
    mode_next    = mode;
    pchar_next   = pchar;
    pplayer_next = pplayer;
    dcnt_next    = dcnt;
    pdir_next    = pdir;
    col_next     = col_count;
    row_next     = row_count;
    first_next   = first_cols;
    prev_nl_next = prev_nl;
    r[0]         = '0;
    r[1]         = '0;
    nres         = 2'd0;
    do_reset     = 1'b0;
    hgt          = row_count;
    c_nl         = col_count;

    case (head.cls)
      gmtp_pkg::CLS_END: begin
        if (pending) begin
          r[0] = '{gmtp_pkg::KIND_OBJECT, pchar, pplayer, pdir, col_count, row_out,
                   '0, '0, 1'b0};
          nres = 2'd1;
        end
        if (!prev_nl && row_count < gmtp_pkg::ROW_W'(gmtp_pkg::MAX_ROWS)) begin
          hgt = row_count + 1'b1;
        end
        r[nres[0]] = '{gmtp_pkg::KIND_END, '0, '0, '0, '0, '0, first_cols, hgt, 1'b0};
        nres = nres + 1'b1;
        do_reset = 1'b1;
      end
      gmtp_pkg::CLS_NL: begin
        // Orientation mode keeps its pending object across a newline
        if (mode == gmtp_pkg::MODE_PLAYER) begin
          r[0] = '{gmtp_pkg::KIND_OBJECT, pchar, pplayer, pdir, col_count, row_out,
                   '0, '0, 1'b0};
          nres = 2'd1;
          mode_next = gmtp_pkg::MODE_NORMAL;
          pdir_next = gmtp_pkg::DIR_NONE;
          c_nl = col_a;
        end
        if (row_count == '0) begin
          first_next = c_nl;
        end
        if (row_count != '0 && first_cols != c_nl) begin
          r[nres[0]] = '{gmtp_pkg::KIND_ROWLEN, '0, '0, '0, c_nl, row_out, '0, '0, 1'b0};
          nres = nres + 1'b1;
          do_reset = 1'b1;
        end else begin
          if (row_count < gmtp_pkg::ROW_W'(gmtp_pkg::MAX_ROWS)) begin
            row_next = row_count + 1'b1;
          end
          col_next = '0;
          prev_nl_next = 1'b1;
        end
      end
      gmtp_pkg::CLS_BLANK, gmtp_pkg::CLS_DOT, gmtp_pkg::CLS_SLASH: begin
        if (pending) begin
          r[0] = '{gmtp_pkg::KIND_OBJECT, pchar, pplayer, pdir, col_count, row_out,
                   '0, '0, 1'b0};
          nres = 2'd1;
          mode_next = gmtp_pkg::MODE_NORMAL;
          pdir_next = gmtp_pkg::DIR_NONE;
        end
        if (head.cls == gmtp_pkg::CLS_BLANK) begin
          col_next = pending ? col_a : col_count;
        end else begin
          prev_nl_next = 1'b0;
          if (head.cls == gmtp_pkg::CLS_DOT) begin
            col_next = pending ? col_b : col_a;
          end
        end
      end
      gmtp_pkg::CLS_LBR: begin
        if (mode == gmtp_pkg::MODE_PLAYER) begin
          mode_next = gmtp_pkg::MODE_ORIENT;
        end
        prev_nl_next = 1'b0;
      end
      gmtp_pkg::CLS_RBR: begin
        if (mode != gmtp_pkg::MODE_ORIENT) begin
          r[0] = '{gmtp_pkg::KIND_BRACKET, '0, '0, '0, col_count, row_out, '0, '0, 1'b0};
          nres = 2'd1;
          do_reset = 1'b1;
        end else begin
          prev_nl_next = 1'b0;
        end
      end
      default: begin
        prev_nl_next = 1'b0;
        if (mode == gmtp_pkg::MODE_ORIENT) begin
          if (head.cls == gmtp_pkg::CLS_DIRL) begin
            pdir_next = head.dir;
          end else begin
            r[0] = '{gmtp_pkg::KIND_BADDIR, head.ch, '0, '0, col_count, row_out,
                     '0, '0, 1'b0};
            nres = 2'd1;
            do_reset = 1'b1;
          end
        end else if (mode == gmtp_pkg::MODE_PLAYER) begin
          if (head.cls == gmtp_pkg::CLS_DIGIT) begin
            // Drop digits beyond PLAYER_DIGITS; the id saturates at PID_MAX
            if (dcnt < gmtp_pkg::DCNT_W'(gmtp_pkg::PLAYER_DIGITS)) begin
              pplayer_next = (pid_acc > 14'(gmtp_pkg::PID_MAX)) ?
                             gmtp_pkg::PID_W'(gmtp_pkg::PID_MAX) : pid_acc[gmtp_pkg::PID_W-1:0];
              dcnt_next = dcnt + 1'b1;
            end
          end else begin
            r[0] = '{gmtp_pkg::KIND_OBJECT, pchar, pplayer, pdir, col_count, row_out,
                     '0, '0, 1'b0};
            nres = 2'd1;
            pchar_next   = head.ch;
            pplayer_next = '0;
            dcnt_next    = '0;
            pdir_next    = gmtp_pkg::DIR_NONE;
            col_next     = col_a;
          end
        end else begin
          pchar_next   = head.ch;
          pplayer_next = '0;
          dcnt_next    = '0;
          mode_next    = gmtp_pkg::MODE_PLAYER;
        end
      end
    endcase

    if (nres == 2'd2) begin
      r[1].last = 1'b1;
    end else if (nres == 2'd1) begin
      r[0].last = 1'b1;
    end

    if (do_reset) begin
      mode_next    = gmtp_pkg::MODE_NORMAL;
      pchar_next   = '0;
      pplayer_next = '0;
      dcnt_next    = '0;
      pdir_next    = gmtp_pkg::DIR_NONE;
      col_next     = '0;
      row_next     = '0;
      first_next   = '0;
      prev_nl_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= gmtp_pkg::MODE_NORMAL;
      pchar     <= '0;
      pplayer   <= '0;
      dcnt      <= '0;
      pdir      <= gmtp_pkg::DIR_NONE;
      col_count <= '0;
      row_count <= '0;
      first_cols <= '0;
      prev_nl   <= 1'b1;
    end else if (pop) begin
      mode      <= mode_next;
      pchar     <= pchar_next;
      pplayer   <= pplayer_next;
      dcnt      <= dcnt_next;
      pdir      <= pdir_next;
      col_count <= col_next;
      row_count <= row_next;
      first_cols <= first_next;
      prev_nl   <= prev_nl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      occ   <= '0;
    end else begin
      if (pop) begin
        owptr <= owptr + gmtp_pkg::OQ_AW'(nres);
      end
      if (out_take) begin
        orptr <= orptr + 1'b1;
      end
      occ <= occ + (pop ? gmtp_pkg::OQ_CW'(nres) : '0) - gmtp_pkg::OQ_CW'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && nres != 2'd0) begin
      oq[owptr] <= r[0];
    end
    if (pop && nres == 2'd2) begin
      oq[owptr + 1'b1] <= r[1];
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= gmtp_pkg::OQ_CW'(gmtp_pkg::OQ_DEPTH))
    else $error("result queue overfilled");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    pop && head.cls == gmtp_pkg::CLS_END |=>
      mode == gmtp_pkg::MODE_NORMAL && row_count == '0 && col_count == '0 && prev_nl)
    else $error("end of stream did not restart the parser");

  a_row_sat: assert property (@(posedge clk) disable iff (rst)
    row_count <= gmtp_pkg::ROW_W'(gmtp_pkg::MAX_ROWS))
    else $error("row counter beyond its limit");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    dcnt <= gmtp_pkg::DCNT_W'(gmtp_pkg::PLAYER_DIGITS))
    else $error("too many player id digits taken");
`endif

endmodule

// ===== src/grid_map_text_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the grid map text parser: stream ports around front, queue and back.
//
//  channel | dir | tdata                               | side band
//  --------+-----+-------------------------------------+---------------------
//  s_*     | in  | ch[7:0]                             | tuser[0] = op
//  m_*     | out | kind..map_height, 73 bits in 80     | tlast = last
//
// One input item per cycle while the result queue keeps two slots free. An item passes
// through the classify register and the item queue before the back stage takes it;
// a result is registered in the result queue when its item is taken.
// The back stage takes an item only while two result slots are free, since one item
// can make two results (a flushed object before the end or row length result);
// the item queue absorbs that wait.
// Synchronous active-high reset empties both queues and restores parser state.
// Either side may stall freely; items and results wait in the queues.
module grid_map_text_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gmtp_pkg::CH_W-1:0]      s_tdata,   // [7:0] ch
  input  logic [0:0]                     s_tuser,   // [0] op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [2:0] kind, [10:3] map_char, [20:11] player_id, [23:21] direction,
  // [35:24] col, [47:36] row, [59:48] map_width, [72:60] map_height, rest zero
  output logic [gmtp_pkg::TDATA_W-1:0]   m_tdata,
  output logic                           m_tlast
);

  gmtp_pkg::push_t    push;
  logic               push_ready;
  logic               head_valid;
  gmtp_pkg::item_t    head;
  logic               pop;
  gmtp_pkg::result_t  res;

  // Classify each character as it arrives
  gmtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (s_tuser[0]),
    .ch         (s_tdata),
    .push       (push),
    .push_ready (push_ready)
  );

  // Hold classified items while the back stage drains double results
  gmtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Advance parser state and queue the results
  gmtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  // Pack fields from the lowest bit up, zero fill to whole bytes
  assign m_tdata = {{gmtp_pkg::TDATA_PAD{1'b0}}, res.map_height, res.map_width, res.row,
                    res.col, res.direction, res.player_id, res.map_char, res.kind};
  assign m_tlast = res.last;

endmodule
